// ===== sv/mfi_pkg.sv =====
package mfi_pkg;

  // default data path width
  localparam int MFI_WIDTH = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXP,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } mfi_state_t;

endpackage

// ===== sv/mfi_mulmod.sv =====
module mfi_mulmod
  import mfi_pkg::*;
#(
  parameter int WIDTH = MFI_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  input  logic [WIDTH-1:0] modulus,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  logic             busy_r, busy_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] dbl_r, dbl_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH:0]   sum_acc, sum_dbl;
  logic [WIDTH:0]   red_acc, red_dbl;

  // modular add of accumulator and doubled operand, and modular doubling of that operand, both below the modulus
  always_comb begin
    sum_acc = {1'b0, acc_r} + {1'b0, dbl_r};
    sum_dbl = {1'b0, dbl_r} + {1'b0, dbl_r};
    red_acc = (sum_acc >= {1'b0, m_r}) ? sum_acc - {1'b0, m_r} : sum_acc;
    red_dbl = (sum_dbl >= {1'b0, m_r}) ? sum_dbl - {1'b0, m_r} : sum_dbl;
  end

  // one multiplier bit per cycle, stop once no set bits remain
  assign done    = busy_r && (b_r == '0);
  assign product = acc_r;

  always_comb begin
    busy_nxt = busy_r;
    acc_nxt  = acc_r;
    dbl_nxt  = dbl_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    if (start) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      dbl_nxt  = op_a;
      b_nxt    = op_b;
      m_nxt    = modulus;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (b_r[0]) begin
          acc_nxt = red_acc[WIDTH-1:0];
        end
        dbl_nxt = red_dbl[WIDTH-1:0];
        b_nxt   = b_r >> 1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    dbl_r <= dbl_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
  end

endmodule

// ===== sv/modular_inverse_fermat.sv =====
// Modular exponentiation base_value^(modulus-2) mod modulus, the Fermat inverse
// when modulus is prime. The base is first reduced, then the exponent is scanned
// from its lowest bit by square-and-multiply. All products run on one shared
// add-and-double modular multiplier that retires one multiplier bit per cycle,
// so the time a product takes is set by the bit length of its second operand.
// An item takes the reduction plus one square per exponent bit up to the top
// set bit and one extra product per set bit. A modulus below two answers 0
// with no product. in_tready is high only while the sequencer is idle; the
// result sits in an output register, so the next word is taken while the last
// result waits.
module modular_inverse_fermat
  import mfi_pkg::*;
#(
  parameter int WIDTH = MFI_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // base_value [WIDTH-1:0], modulus [2*WIDTH-1:WIDTH]
  input  logic [((2*WIDTH+7)/8)*8-1:0]         in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // inverse_value [WIDTH-1:0]
  output logic [((WIDTH+7)/8)*8-1:0]           out_tdata
);

  localparam int OUT_TW = ((WIDTH + 7) / 8) * 8;

  mfi_state_t       state_r, state_nxt;
  logic [WIDTH-1:0] m_r, expo_r, base_r, result_r;
  logic             out_valid_r;
  logic [WIDTH-1:0] out_data_r;

  logic [WIDTH-1:0] in_base, in_mod;
  logic             in_accept, mod_small, out_load;
  logic             mul_start, mul_done;
  logic [WIDTH-1:0] mul_a, mul_b, mul_m, mul_p;

  // input fields
  assign in_base   = in_tdata[WIDTH-1:0];
  assign in_mod    = in_tdata[2*WIDTH-1:WIDTH];
  assign in_accept = in_tvalid && in_tready;
  assign mod_small = (in_mod < WIDTH'(2));
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // shared modular multiplier
  mfi_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .modulus(mul_m),
    .done   (mul_done),
    .product(mul_p)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = mod_small ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mul_done) state_nxt = ST_EXP;
      end
      ST_EXP: begin
        if (expo_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = expo_r[0] ? ST_MUL : ST_SQR;
        end
      end
      ST_MUL: begin
        if (mul_done) state_nxt = ST_SQR;
      end
      ST_SQR: begin
        if (mul_done) state_nxt = ST_EXP;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: handshake and multiplier requests
  always_comb begin
    in_tready = 1'b0;
    mul_start = 1'b0;
    mul_a     = base_r;
    mul_b     = base_r;
    mul_m     = m_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        // reduction of the base as 1 * base_value mod modulus
        mul_start = in_tvalid && !mod_small;
        mul_a     = {{(WIDTH-1){1'b0}}, 1'b1};
        mul_b     = in_base;
        mul_m     = in_mod;
      end
      ST_EXP: begin
        mul_start = (expo_r != '0);
        if (expo_r[0]) mul_a = result_r;
      end
      ST_MUL: begin
        mul_start = mul_done;
      end
      ST_REDUCE, ST_SQR, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // data path registers
  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= result_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          m_r      <= in_mod;
          expo_r   <= in_mod - WIDTH'(2);
          result_r <= mod_small ? '0 : {{(WIDTH-1){1'b0}}, 1'b1};
        end
      end
      ST_REDUCE: begin
        if (mul_done) base_r <= mul_p;
      end
      ST_MUL: begin
        if (mul_done) result_r <= mul_p;
      end
      ST_SQR: begin
        if (mul_done) begin
          base_r <= mul_p;
          expo_r <= expo_r >> 1;
        end
      end
      ST_EXP, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'(out_data_r);

`ifndef NO_ASSERTIONS
  // the multiplier never finishes while the sequencer is idle or finished
  a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !mul_done)
    else $error("multiplier done outside an exponentiation");

  // operands stay reduced during the exponent scan
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXP || state_r == ST_MUL || state_r == ST_SQR)
      |-> (base_r < m_r && result_r < m_r))
    else $error("operand not reduced by modulus");

  // a delivered result is below its modulus when the modulus is at least two
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && m_r >= WIDTH'(2)) |=> (out_data_r < $past(m_r)))
    else $error("result not below modulus");
`endif

endmodule
